// ===== sv/omdw_pkg.sv =====
// ----------------------------------------------------------------------------
// omdw_pkg: shared types and codes for the owned semaphore table
// Operation and status codes, cell commands and the scan candidate record.
// ----------------------------------------------------------------------------
package omdw_pkg;

   localparam int FUNC_W    = 2;
   localparam int STATUS_W  = 4;
   localparam int TASK_W    = 4;
   localparam int SEM_ID_W  = 4;
   localparam int REQ_DL_W  = 16;
   localparam int CFG_W     = 5;
   localparam int ADDR_W    = 2;
   localparam int DATA_W    = 32;

   localparam logic [FUNC_W-1:0] FUNC_INIT    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TAKE    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK         = 4'd0;
   localparam logic [STATUS_W-1:0] ST_BLOCKED    = 4'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_ID     = 4'd2;
   localparam logic [STATUS_W-1:0] ST_INTERRUPT  = 4'd3;
   localparam logic [STATUS_W-1:0] ST_NO_TASK    = 4'd4;
   localparam logic [STATUS_W-1:0] ST_NESTED     = 4'd5;
   localparam logic [STATUS_W-1:0] ST_NOT_LOCKED = 4'd6;
   localparam logic [STATUS_W-1:0] ST_NOT_OWNER  = 4'd7;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW  = 4'd8;

   localparam logic [ADDR_W-1:0] ADDR_TASKS_IN_USE = 2'd0;
   localparam logic [CFG_W-1:0]  TASKS_IN_USE_RST  = 5'd16;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_GRANT,
      CMD_BLOCK,
      CMD_DEC,
      CMD_WAKE
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type            op;
      logic [TASK_W-1:0]     task_id;
      logic [SEM_ID_W-1:0]   sem;
      logic [REQ_DL_W-1:0]   deadline;
   } cell_cmd_type;

   typedef struct packed {
      logic                  found;
      logic [TASK_W-1:0]     idx;
      logic [REQ_DL_W-1:0]   deadline;
   } cand_type;

endpackage

// ===== sv/omdw_cell.sv =====
// ----------------------------------------------------------------------------
// omdw_cell: one task slot of the wait chain
// Holds the slot's wait flag, semaphore, deadline and held-lock count, and
// passes the best waiter found so far on to the next slot every cycle.
// ----------------------------------------------------------------------------
module omdw_cell #(
   parameter int IDX   = 0,
   parameter int SEM_W = 3,
   parameter int DL_W  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  omdw_pkg::cell_cmd_type         cmd,
   input  logic [omdw_pkg::CFG_W-1:0]     tasks_in_use,
   input  omdw_pkg::cand_type             cand_in,
   output omdw_pkg::cand_type             cand_out,
   output logic                           held_zero
);

   localparam int EXT_W = omdw_pkg::REQ_DL_W;
   localparam int TW    = omdw_pkg::TASK_W;
   localparam int CW    = omdw_pkg::CFG_W;

   logic                  waiting_ff, waiting_in;
   logic [SEM_W-1:0]      wsem_ff, wsem_in;
   logic [DL_W-1:0]       dl_ff, dl_in;
   logic [TW-1:0]         held_ff, held_in;
   omdw_pkg::cand_type    cand_ff, cand_in_next;

   logic                  sel;
   logic                  match;
   logic                  take;
   logic [EXT_W-1:0]      dl_ext;

   always_comb begin
      sel        = (cmd.task_id == TW'(IDX));
      waiting_in = waiting_ff;
      wsem_in    = wsem_ff;
      dl_in      = dl_ff;
      held_in    = held_ff;
      if (sel) begin
         case (cmd.op)
            omdw_pkg::CMD_GRANT: begin
               // saturate the held count
               if (held_ff != '1) begin
                  held_in = held_ff + TW'(1);
               end
               waiting_in = 1'b0;
               wsem_in    = '0;
            end
            omdw_pkg::CMD_BLOCK: begin
               waiting_in = 1'b1;
               wsem_in    = cmd.sem[SEM_W-1:0];
               dl_in      = cmd.deadline[DL_W-1:0];
            end
            omdw_pkg::CMD_DEC: begin
               held_in = held_ff - TW'(1);
            end
            omdw_pkg::CMD_WAKE: begin
               waiting_in = 1'b0;
            end
            default: begin
            end
         endcase
      end

      // strict compare keeps the lower index on equal deadlines
      dl_ext = EXT_W'(dl_ff);
      match  = waiting_ff && (wsem_ff == cmd.sem[SEM_W-1:0]) && (tasks_in_use > CW'(IDX));
      take   = match && (!cand_in.found || (dl_ext < cand_in.deadline));
      if (take) begin
         cand_in_next.found    = 1'b1;
         cand_in_next.idx      = TW'(IDX);
         cand_in_next.deadline = dl_ext;
      end else begin
         cand_in_next = cand_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff <= 1'b0;
         wsem_ff    <= '0;
         held_ff    <= '0;
      end else begin
         waiting_ff <= waiting_in;
         wsem_ff    <= wsem_in;
         held_ff    <= held_in;
      end
      dl_ff   <= dl_in;
      cand_ff <= cand_in_next;
   end

   assign cand_out  = cand_ff;
   assign held_zero = (held_ff == '0);

endmodule

// ===== sv/owned_mutex_deadline_wake.sv =====
// ----------------------------------------------------------------------------
// owned_mutex_deadline_wake: owned binary semaphores, earliest-deadline wake
// Init, take and faulted requests pass from the check state to the done state;
// a good release also walks the wait chain in the scan state, which moves one
// task slot per cycle. One request is in flight at a time: the next request is
// taken only once the result has moved to the reply register.
// Reset (synchronous, active high) frees all semaphores, clears all waiters
// and held counts, and sets tasks_in_use to 16.
// ----------------------------------------------------------------------------
module owned_mutex_deadline_wake #(
   parameter int NUM_SEMS      = 8,
   parameter int NUM_TASKS     = 16,
   parameter int DEADLINE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [omdw_pkg::FUNC_W-1:0]         req_func,
   input  logic [omdw_pkg::SEM_ID_W-1:0]       req_sem_id,
   input  logic [omdw_pkg::TASK_W-1:0]         req_task_id,
   input  logic                                req_task_present,
   input  logic                                req_in_interrupt,
   input  logic [omdw_pkg::REQ_DL_W-1:0]       req_task_deadline,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [omdw_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_woke_valid,
   output logic [omdw_pkg::TASK_W-1:0]         rsp_woke_task,

   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [omdw_pkg::ADDR_W-1:0]         paddr,
   input  logic [omdw_pkg::DATA_W-1:0]         pwdata,
   output logic [omdw_pkg::DATA_W-1:0]         prdata,
   output logic                                pready
);

   localparam int TW    = omdw_pkg::TASK_W;
   localparam int SW    = omdw_pkg::SEM_ID_W;
   localparam int STW   = omdw_pkg::STATUS_W;
   localparam int CW    = omdw_pkg::CFG_W;
   localparam int DL_W  = (DEADLINE_BITS < omdw_pkg::REQ_DL_W) ? DEADLINE_BITS
                                                                : omdw_pkg::REQ_DL_W;
   localparam int SEM_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int TID_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int CNT_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_TASKS - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_DONE
   } state_type;

   state_type                        state_ff, state_in;
   logic [omdw_pkg::FUNC_W-1:0]      func_ff, func_in;
   logic [SW-1:0]                    sem_ff, sem_in;
   logic [TW-1:0]                    task_ff, task_in;
   logic                             present_ff, present_in;
   logic                             isr_ff, isr_in;
   logic [omdw_pkg::REQ_DL_W-1:0]    dl_ff, dl_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic [STW-1:0]                   res_status_ff, res_status_in;
   logic                             res_woke_ff, res_woke_in;
   logic [TW-1:0]                    res_task_ff, res_task_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [STW-1:0]                   rsp_status_ff, rsp_status_in;
   logic                             rsp_woke_ff, rsp_woke_in;
   logic [TW-1:0]                    rsp_task_ff, rsp_task_in;
   logic [CW-1:0]                    tiu_ff, tiu_in;
   logic                             locked_ff [NUM_SEMS];
   logic                             locked_in [NUM_SEMS];
   logic [TW-1:0]                    owner_ff  [NUM_SEMS];
   logic [TW-1:0]                    owner_in  [NUM_SEMS];

   omdw_pkg::cell_cmd_type           cmd;
   omdw_pkg::cand_type               cand [NUM_TASKS+1];
   logic [NUM_TASKS-1:0]             held_zero;

   logic [SEM_W-1:0]                 sidx;
   logic [TID_W-1:0]                 tidx;
   logic                             sem_bad;
   logic                             task_bad;
   logic                             lk;
   logic [TW-1:0]                    ow;
   logic                             hz;
   logic                             csr_write;

   assign cand[0] = '0;

   for (genvar gi = 0; gi < NUM_TASKS; gi++) begin : g_cell
      omdw_cell #(
         .IDX   (gi),
         .SEM_W (SEM_W),
         .DL_W  (DL_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .tasks_in_use (tiu_ff),
         .cand_in      (cand[gi]),
         .cand_out     (cand[gi+1]),
         .held_zero    (held_zero[gi])
      );
   end

   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = (paddr == omdw_pkg::ADDR_TASKS_IN_USE)
                      ? omdw_pkg::DATA_W'(tiu_ff) : '0;

   always_comb begin
      sidx     = sem_ff[SEM_W-1:0];
      tidx     = task_ff[TID_W-1:0];
      sem_bad  = ({1'b0, sem_ff} >= (SW+1)'(NUM_SEMS));
      task_bad = ({1'b0, task_ff} >= (TW+1)'(NUM_TASKS));
      lk       = locked_ff[sidx];
      ow       = owner_ff[sidx];
      hz       = held_zero[tidx];

      state_in      = state_ff;
      func_in       = func_ff;
      sem_in        = sem_ff;
      task_in       = task_ff;
      present_in    = present_ff;
      isr_in        = isr_ff;
      dl_in         = dl_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_woke_in   = res_woke_ff;
      res_task_in   = res_task_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_woke_in   = rsp_woke_ff;
      rsp_task_in   = rsp_task_ff;
      locked_in     = locked_ff;
      owner_in      = owner_ff;
      tiu_in        = tiu_ff;

      cmd.op        = omdw_pkg::CMD_NONE;
      cmd.task_id   = task_ff;
      cmd.sem       = sem_ff;
      cmd.deadline  = dl_ff;

      req_ready     = (state_ff == S_IDLE);

      if (csr_write && (paddr == omdw_pkg::ADDR_TASKS_IN_USE)) begin
         tiu_in = pwdata[CW-1:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in    = req_func;
               sem_in     = req_sem_id;
               task_in    = req_task_id;
               present_in = req_task_present;
               isr_in     = req_in_interrupt;
               dl_in      = req_task_deadline;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            res_status_in = omdw_pkg::ST_OK;
            res_woke_in   = 1'b0;
            res_task_in   = '0;
            state_in      = S_DONE;
            if (func_ff == omdw_pkg::FUNC_INIT) begin
               if (sem_bad) begin
                  res_status_in = omdw_pkg::ST_BAD_ID;
               end else begin
                  locked_in[sidx] = 1'b0;
                  owner_in[sidx]  = '0;
               end
            end else if (func_ff == omdw_pkg::FUNC_TAKE ||
                         func_ff == omdw_pkg::FUNC_RELEASE) begin
               if (sem_bad) begin
                  res_status_in = omdw_pkg::ST_BAD_ID;
               end else if (isr_ff) begin
                  res_status_in = omdw_pkg::ST_INTERRUPT;
               end else if (!present_ff) begin
                  res_status_in = omdw_pkg::ST_NO_TASK;
               end else if (task_bad) begin
                  res_status_in = omdw_pkg::ST_BAD_ID;
               end else if (func_ff == omdw_pkg::FUNC_TAKE) begin
                  if (lk && ow == task_ff) begin
                     res_status_in = omdw_pkg::ST_NESTED;
                  end else if (!lk) begin
                     locked_in[sidx] = 1'b1;
                     owner_in[sidx]  = task_ff;
                     cmd.op          = omdw_pkg::CMD_GRANT;
                  end else begin
                     cmd.op        = omdw_pkg::CMD_BLOCK;
                     res_status_in = omdw_pkg::ST_BLOCKED;
                  end
               end else begin
                  if (!lk) begin
                     res_status_in = omdw_pkg::ST_NOT_LOCKED;
                  end else if (ow != task_ff) begin
                     res_status_in = omdw_pkg::ST_NOT_OWNER;
                  end else if (hz) begin
                     res_status_in = omdw_pkg::ST_UNDERFLOW;
                  end else begin
                     // free the lock now, then walk the chain for a waiter
                     locked_in[sidx] = 1'b0;
                     owner_in[sidx]  = '0;
                     cmd.op          = omdw_pkg::CMD_DEC;
                     cnt_in          = '0;
                     state_in        = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               // chain tail now holds the winner over all slots
               if (cand[NUM_TASKS].found) begin
                  cmd.op      = omdw_pkg::CMD_WAKE;
                  cmd.task_id = cand[NUM_TASKS].idx;
                  res_woke_in = 1'b1;
                  res_task_in = cand[NUM_TASKS].idx;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_woke_in   = res_woke_ff;
               rsp_task_in   = res_task_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         tiu_ff       <= omdw_pkg::TASKS_IN_USE_RST;
         for (int i = 0; i < NUM_SEMS; i++) begin
            locked_ff[i] <= 1'b0;
            owner_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tiu_ff       <= tiu_in;
         locked_ff    <= locked_in;
         owner_ff     <= owner_in;
      end
      func_ff       <= func_in;
      sem_ff        <= sem_in;
      task_ff       <= task_in;
      present_ff    <= present_in;
      isr_ff        <= isr_in;
      dl_ff         <= dl_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_woke_ff   <= res_woke_in;
      res_task_ff   <= res_task_in;
      rsp_status_ff <= rsp_status_in;
      rsp_woke_ff   <= rsp_woke_in;
      rsp_task_ff   <= rsp_task_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_woke_valid = rsp_woke_ff;
   assign rsp_woke_task  = rsp_task_ff;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: owned semaphore table with earliest-deadline wakeup
// Drives init, take and release requests through the valid/ready channel,
// predicts each reply from a local copy of the semaphore and waiter tables,
// and checks every reply in order. The scan length register is swept
// through its extremes between phases, with random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;

   localparam int NUM_SEMS      = 8;
   localparam int NUM_TASKS     = 16;
   localparam int DEADLINE_BITS = 16;
   localparam int LONG_HOLD     = 300;
   localparam int SCAN_SETTLE   = NUM_TASKS + 8;

   localparam int FW  = omdw_pkg::FUNC_W;
   localparam int SW  = omdw_pkg::SEM_ID_W;
   localparam int TW  = omdw_pkg::TASK_W;
   localparam int DW  = omdw_pkg::REQ_DL_W;
   localparam int STW = omdw_pkg::STATUS_W;
   localparam int CW  = omdw_pkg::CFG_W;
   localparam int AW  = omdw_pkg::ADDR_W;
   localparam int PW  = omdw_pkg::DATA_W;

   localparam logic [FW-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [FW-1:0]   func;
      logic [SW-1:0]   sem;
      logic [TW-1:0]   caller;
      logic            present;
      logic            isr;
      logic [DW-1:0]   deadline;
   } sem_call_type;

   typedef struct packed {
      logic [STW-1:0]  status;
      logic            woke_valid;
      logic [TW-1:0]   woke_task;
   } sem_reply_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   logic [FW-1:0]   req_func;
   logic [SW-1:0]   req_sem_id;
   logic [TW-1:0]   req_task_id;
   logic            req_task_present;
   logic            req_in_interrupt;
   logic [DW-1:0]   req_task_deadline;
   logic            rsp_valid;
   logic            rsp_ready;
   logic [STW-1:0]  rsp_status;
   logic            rsp_woke_valid;
   logic [TW-1:0]   rsp_woke_task;
   logic            psel;
   logic            penable;
   logic            pwrite;
   logic [AW-1:0]   paddr;
   logic [PW-1:0]   pwdata;
   logic [PW-1:0]   prdata;
   logic            pready;

   // shadow copy of the block's tables
   logic            sem_held    [NUM_SEMS];
   logic [TW-1:0]   sem_holder  [NUM_SEMS];
   logic            waiting     [NUM_TASKS];
   logic [SW-1:0]   wait_sem    [NUM_TASKS];
   logic [DW-1:0]   wait_dl     [NUM_TASKS];
   logic [3:0]      held_count  [NUM_TASKS];
   logic [CW-1:0]   scan_limit;

   sem_reply_type pending_replies[$];
   sem_reply_type oldest;
   int            fail_count;
   bit            hold_wanted;

   owned_mutex_deadline_wake #(
      .NUM_SEMS      (NUM_SEMS),
      .NUM_TASKS     (NUM_TASKS),
      .DEADLINE_BITS (DEADLINE_BITS)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_sem_id        (req_sem_id),
      .req_task_id       (req_task_id),
      .req_task_present  (req_task_present),
      .req_in_interrupt  (req_in_interrupt),
      .req_task_deadline (req_task_deadline),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_woke_valid    (rsp_woke_valid),
      .rsp_woke_task     (rsp_woke_task),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic void clear_tables();
      for (int i = 0; i < NUM_SEMS; i++) begin
         sem_held[i]   = 1'b0;
         sem_holder[i] = '0;
      end
      for (int i = 0; i < NUM_TASKS; i++) begin
         waiting[i]    = 1'b0;
         wait_sem[i]   = '0;
         wait_dl[i]    = '0;
         held_count[i] = '0;
      end
      scan_limit = omdw_pkg::TASKS_IN_USE_RST;
   endfunction

   // Apply one request to the shadow tables and return the reply it earns.
   function automatic sem_reply_type resolve_sem_call(sem_call_type c);
      sem_reply_type r;
      int            limit;
      bit            found;
      int            best;
      r.status     = omdw_pkg::ST_OK;
      r.woke_valid = 1'b0;
      r.woke_task  = '0;
      if (c.func == omdw_pkg::FUNC_INIT) begin
         if (c.sem >= NUM_SEMS) begin
            r.status = omdw_pkg::ST_BAD_ID;
         end else begin
            sem_held[c.sem]   = 1'b0;
            sem_holder[c.sem] = '0;
         end
      end else if (c.func == omdw_pkg::FUNC_TAKE || c.func == omdw_pkg::FUNC_RELEASE) begin
         if (c.sem >= NUM_SEMS)
            r.status = omdw_pkg::ST_BAD_ID;
         else if (c.isr)
            r.status = omdw_pkg::ST_INTERRUPT;
         else if (!c.present)
            r.status = omdw_pkg::ST_NO_TASK;
         else if (c.caller >= NUM_TASKS)
            r.status = omdw_pkg::ST_BAD_ID;
         else if (c.func == omdw_pkg::FUNC_TAKE) begin
            if (sem_held[c.sem] && sem_holder[c.sem] == c.caller) begin
               r.status = omdw_pkg::ST_NESTED;
            end else if (!sem_held[c.sem]) begin
               sem_held[c.sem]   = 1'b1;
               sem_holder[c.sem] = c.caller;
               if (held_count[c.caller] != 4'd15)
                  held_count[c.caller] = held_count[c.caller] + 4'd1;
               waiting[c.caller]  = 1'b0;
               wait_sem[c.caller] = '0;
            end else begin
               waiting[c.caller]  = 1'b1;
               wait_sem[c.caller] = c.sem;
               wait_dl[c.caller]  = c.deadline;
               r.status = omdw_pkg::ST_BLOCKED;
            end
         end else begin
            if (!sem_held[c.sem]) begin
               r.status = omdw_pkg::ST_NOT_LOCKED;
            end else if (sem_holder[c.sem] != c.caller) begin
               r.status = omdw_pkg::ST_NOT_OWNER;
            end else if (held_count[c.caller] == 4'd0) begin
               r.status = omdw_pkg::ST_UNDERFLOW;
            end else begin
               limit = (scan_limit > NUM_TASKS) ? NUM_TASKS : int'(scan_limit);
               found = 1'b0;
               best  = 0;
               held_count[c.caller] = held_count[c.caller] - 4'd1;
               sem_held[c.sem]   = 1'b0;
               sem_holder[c.sem] = '0;
               // strict compare keeps the lowest index on a deadline tie
               for (int i = 0; i < limit; i++) begin
                  if (waiting[i] && wait_sem[i] == c.sem) begin
                     if (!found || wait_dl[i] < wait_dl[best]) begin
                        best  = i;
                        found = 1'b1;
                     end
                  end
               end
               if (found) begin
                  waiting[best] = 1'b0;
                  r.woke_valid  = 1'b1;
                  r.woke_task   = best[TW-1:0];
               end
            end
         end
      end
      return r;
   endfunction

   function automatic sem_call_type sem_call(logic [FW-1:0] f, int s, int t,
                                             bit p, bit i, logic [DW-1:0] d);
      sem_call_type c;
      c.func     = f;
      c.sem      = s[SW-1:0];
      c.caller   = t[TW-1:0];
      c.present  = p;
      c.isr      = i;
      c.deadline = d;
      return c;
   endfunction

   // Mostly well-formed init, take and release traffic, with some raw noise.
   function automatic sem_call_type pick_call();
      sem_call_type c;
      int           roll;
      roll      = $urandom_range(0, 99);
      c.sem     = SW'($urandom_range(0, NUM_SEMS - 1));
      c.caller  = TW'($urandom_range(0, NUM_TASKS - 1));
      c.present = 1'b1;
      c.isr     = 1'b0;
      case ($urandom_range(0, 5))
         0: c.deadline = 16'h0000;
         1: c.deadline = 16'hFFFF;
         2: c.deadline = 16'h0100;
         default: c.deadline = DW'($urandom_range(0, 65535));
      endcase
      if (roll < 12) begin
         c.func    = FW'($urandom_range(0, 3));
         c.sem     = SW'($urandom_range(0, 15));
         c.present = 1'($urandom_range(0, 1));
         c.isr     = 1'($urandom_range(0, 1));
      end else if (roll < 20) begin
         c.func = omdw_pkg::FUNC_INIT;
      end else if (roll < 58) begin
         c.func = omdw_pkg::FUNC_TAKE;
      end else begin
         c.func = omdw_pkg::FUNC_RELEASE;
         for (int k = 0; k < 4 && !sem_held[c.sem]; k++)
            c.sem = SW'($urandom_range(0, NUM_SEMS - 1));
         // release by the holder most of the time so waiters get woken
         if (sem_held[c.sem] && $urandom_range(0, 9) != 0)
            c.caller = sem_holder[c.sem];
      end
      return c;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_call(input sem_call_type c);
      req_valid         = 1'b1;
      req_func          = c.func;
      req_sem_id        = c.sem;
      req_task_id       = c.caller;
      req_task_present  = c.present;
      req_in_interrupt  = c.isr;
      req_task_deadline = c.deadline;
      do @(posedge clock); while (!req_ready);
      pending_replies.push_back(resolve_sem_call(c));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic idle_cycles(input int n);
      req_valid = 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain_replies(input int extra);
      req_valid = 1'b0;
      while (pending_replies.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_tasks_in_use(input logic [CW-1:0] v);
      logic [PW-1:0] got;
      drain_replies(SCAN_SETTLE);
      paddr   = omdw_pkg::ADDR_TASKS_IN_USE;
      pwdata  = PW'(v);
      pwrite  = 1'b1;
      psel    = 1'b1;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      scan_limit = v;
      @(negedge clock);
      pwrite  = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      if (got !== PW'(v)) begin
         $error("tasks_in_use readback: expected %0d, got %0d", v, got);
         fail_count++;
      end
   endtask

   task automatic test_directed_calls();
      sem_call_type list[$];
      list.push_back(sem_call(omdw_pkg::FUNC_INIT,    15, 0,  0, 1, 16'h0000));
      list.push_back(sem_call(omdw_pkg::FUNC_INIT,    3,  5,  1, 0, 16'hFFFF));
      list.push_back(sem_call(FUNC_UNUSED,            15, 15, 1, 1, 16'hFFFF));
      list.push_back(sem_call(omdw_pkg::FUNC_TAKE,    8,  2,  1, 0, 16'd10));
      list.push_back(sem_call(omdw_pkg::FUNC_TAKE,    0,  2,  1, 1, 16'd10));
      list.push_back(sem_call(omdw_pkg::FUNC_TAKE,    0,  2,  0, 0, 16'd10));
      list.push_back(sem_call(omdw_pkg::FUNC_TAKE,    0,  15, 1, 0, 16'd0));
      list.push_back(sem_call(omdw_pkg::FUNC_TAKE,    0,  15, 1, 0, 16'd0));
      list.push_back(sem_call(omdw_pkg::FUNC_TAKE,    0,  3,  1, 0, 16'd500));
      list.push_back(sem_call(omdw_pkg::FUNC_TAKE,    0,  9,  1, 0, 16'd200));
      list.push_back(sem_call(omdw_pkg::FUNC_TAKE,    0,  1,  1, 0, 16'd200));
      list.push_back(sem_call(omdw_pkg::FUNC_TAKE,    0,  0,  1, 0, 16'hFFFF));
      list.push_back(sem_call(omdw_pkg::FUNC_RELEASE, 0,  3,  1, 0, 16'd0));
      list.push_back(sem_call(omdw_pkg::FUNC_RELEASE, 5,  3,  1, 0, 16'd0));
      list.push_back(sem_call(omdw_pkg::FUNC_RELEASE, 0,  15, 1, 1, 16'd0));
      list.push_back(sem_call(omdw_pkg::FUNC_RELEASE, 0,  15, 0, 0, 16'd0));
      list.push_back(sem_call(omdw_pkg::FUNC_RELEASE, 12, 15, 1, 0, 16'd0));
      list.push_back(sem_call(omdw_pkg::FUNC_RELEASE, 0,  15, 1, 0, 16'd0));
      list.push_back(sem_call(omdw_pkg::FUNC_TAKE,    0,  1,  1, 0, 16'd200));
      list.push_back(sem_call(omdw_pkg::FUNC_RELEASE, 0,  1,  1, 0, 16'd0));
      list.push_back(sem_call(omdw_pkg::FUNC_TAKE,    7,  9,  1, 0, 16'd0));
      list.push_back(sem_call(omdw_pkg::FUNC_TAKE,    7,  4,  1, 0, 16'd0));
      // init leaves the waiter recorded; the next release still wakes it
      list.push_back(sem_call(omdw_pkg::FUNC_INIT,    7,  0,  1, 0, 16'd0));
      list.push_back(sem_call(omdw_pkg::FUNC_TAKE,    7,  2,  1, 0, 16'd0));
      list.push_back(sem_call(omdw_pkg::FUNC_RELEASE, 7,  2,  1, 0, 16'd0));
      foreach (list[i]) begin
         send_call(list[i]);
         idle_cycles($urandom_range(0, 2));
      end
   endtask

   task automatic test_held_saturation();
      // pump one task's held count past its ceiling through take/init pairs
      for (int i = 0; i < 17; i++) begin
         send_call(sem_call(omdw_pkg::FUNC_TAKE, 2, 6, 1, 0, 16'd0));
         send_call(sem_call(omdw_pkg::FUNC_INIT, 2, 6, 1, 0, 16'd0));
      end
      send_call(sem_call(omdw_pkg::FUNC_TAKE,    2, 6, 1, 0, 16'd0));
      send_call(sem_call(omdw_pkg::FUNC_RELEASE, 2, 6, 1, 0, 16'd0));
   endtask

   task automatic test_random_calls(input logic [CW-1:0] cfg, input int n,
                                    input bit gaps_on);
      int burst_left;
      write_tasks_in_use(cfg);
      burst_left = 0;
      for (int i = 0; i < n; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on)
               idle_cycles($urandom_range(1, 8));
         end
         burst_left--;
         if ($urandom_range(0, 39) == 0)
            drain_replies(0);
         send_call(pick_call());
      end
   endtask

   task automatic test_backpressure();
      hold_wanted = 1'b1;
      for (int i = 0; i < 24; i++)
         send_call(pick_call());
      drain_replies(0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            $error("reply with nothing pending: status %0d", rsp_status);
            fail_count++;
         end else begin
            oldest = pending_replies.pop_front();
            if (rsp_status !== oldest.status) begin
               $error("status: expected %0d, got %0d", oldest.status, rsp_status);
               fail_count++;
            end
            if (rsp_woke_valid !== oldest.woke_valid) begin
               $error("woke_valid: expected %0d, got %0d",
                      oldest.woke_valid, rsp_woke_valid);
               fail_count++;
            end
            if (rsp_woke_task !== oldest.woke_task) begin
               $error("woke_task: expected %0d, got %0d",
                      oldest.woke_task, rsp_woke_task);
               fail_count++;
            end
         end
      end
   end

   // Reply side: random stall modes, plus one long hold when asked.
   initial begin : reply_side
      int mode;
      int span;
      mode      = 0;
      span      = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            rsp_ready   = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
         end
         span--;
         case (mode)
            0: rsp_ready = 1'b1;
            1: rsp_ready = 1'($urandom_range(0, 1));
            2: rsp_ready = ($urandom_range(0, 3) == 0);
            default: rsp_ready = ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   initial begin
      #5_000_000;
      $display("testbench failed");
      $finish;
   end

   initial begin
      fail_count        = 0;
      hold_wanted       = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_func          = omdw_pkg::FUNC_INIT;
      req_sem_id        = '0;
      req_task_id       = '0;
      req_task_present  = 1'b0;
      req_in_interrupt  = 1'b0;
      req_task_deadline = '0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      clear_tables();
      repeat (5) @(negedge clock);
      reset = 1'b0;

      test_directed_calls();
      test_held_saturation();
      test_random_calls(5'd0,  60, 1'b1);
      test_random_calls(5'd31, 70, 1'b0);
      test_backpressure();
      test_random_calls(5'd5,  60, 1'b1);
      test_random_calls(5'd1,  50, 1'b1);
      test_random_calls(5'd16, 75, 1'b1);

      drain_replies(SCAN_SETTLE);
      if (fail_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
